[hw/rtl/png_row_unfilter_assert.svh]
// Assertion macros shared by the PNG row unfilter RTL.
// Every macro samples on clock and is disabled while reset is high.
`ifndef PNG_ROW_UNFILTER_ASSERT_SVH
`define PNG_ROW_UNFILTER_ASSERT_SVH

// Overlapping implication: the consequent holds in the same cycle.
`define PRU_ASSERT_SAME(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Non-overlapping implication: the consequent holds in the cycle after the antecedent.
`define PRU_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

// Invariant that holds in every cycle outside reset.
`define PRU_ASSERT_ALWAYS(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

`endif

[hw/rtl/pru_pkg.sv]
// Package for the PNG row unfilter: sizes, register and filter codes, Paeth predictor.
// Depends on nothing; imported by png_row_unfilter.
package pru_pkg;

   localparam int MAX_ROW_BYTES = 8192;
   localparam int MAX_BPP       = 8;

   localparam int ROW_ADDR_W = $clog2(MAX_ROW_BYTES);
   localparam int COL_W      = $clog2(MAX_ROW_BYTES + 1);
   localparam int SLOT_W     = (MAX_BPP > 1) ? $clog2(MAX_BPP) : 1;

   localparam int BPP_W      = 4;
   localparam int ROW_LEN_W  = 14;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 14;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BPP       = 2'd0,
      CSR_ROW_BYTES = 2'd1
   } csr_index_type;

   typedef enum logic [2:0] {
      FILT_NONE  = 3'd0,
      FILT_SUB   = 3'd1,
      FILT_UP    = 3'd2,
      FILT_AVG   = 3'd3,
      FILT_PAETH = 3'd4,
      FILT_PASS  = 3'd7
   } filter_type;

   // Paeth predictor: picks whichever neighbour is closest to a + b - c,
   // with ties going to a, then b.
   function automatic logic [7:0] paeth_pick(input logic [7:0] a,
                                             input logic [7:0] b,
                                             input logic [7:0] c);
      logic signed [9:0] sa;
      logic signed [9:0] sb;
      logic signed [9:0] sc;
      logic signed [9:0] da;
      logic signed [9:0] db;
      logic signed [9:0] dc;
      logic [9:0]        pa;
      logic [9:0]        pb;
      logic [9:0]        pc;
      logic [7:0]        pick;
      sa = $signed({2'b00, a});
      sb = $signed({2'b00, b});
      sc = $signed({2'b00, c});
      da = sb - sc;
      db = sa - sc;
      dc = sa + sb - (sc <<< 1);
      pa = (da < 0) ? 10'(-da) : 10'(da);
      pb = (db < 0) ? 10'(-db) : 10'(db);
      pc = (dc < 0) ? 10'(-dc) : 10'(dc);
      if (pa <= pb && pa <= pc) begin
         pick = a;
      end else if (pb <= pc) begin
         pick = b;
      end else begin
         pick = c;
      end
      return pick;
   endfunction

endpackage

[hw/rtl/png_row_unfilter.sv]
// PNG scanline unfiltering with a previous-row buffer, one byte per clock unless stalled.
// Depends on pru_pkg and on the assertion macros in png_row_unfilter_assert.svh.
//
// Usage. Decompressed scanline bytes enter as words on the req_ channel and
// reconstructed bytes leave as words on the rsp_ channel, exactly one result
// word for every request word, in order. The first word of each row carries
// the filter type; it comes back with pixel byte 0 and the filter-slot flag
// set. The last pixel word of a row comes back with end_of_row set. Raise
// req_first_of_image on the filter word of an image's first row.
// An accepted word passes through the working stage and then the output
// register before rsp_valid shows it. Throughput is one word per cycle while
// rsp_stall is low: the only loop is the left-neighbour feedback, which
// closes through one adder, one Paeth compare and the small left window;
// the line buffer has one read and one write port per cycle.
// Two csr_ registers (bytes per pixel, row length) are written through a
// port that is always ready; write them only while no word is in flight.
// Reset clears the pipeline, the windows and the column count, and sets the
// registers to 4 and 1024; the line buffer needs no clearing, as the first
// row of an image treats the row above as zero. No clearing pass runs after reset.
// When the receiver raises rsp_stall, the output word holds; req_stall rises in the
// same cycle if the working stage holds a word, else once one more word collects there.

module png_row_unfilter
   import pru_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_data_byte,
   input  logic                  req_first_of_image,

   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [7:0]            rsp_pixel_byte,
   output logic                  rsp_is_filter_slot,
   output logic                  rsp_end_of_row,

   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   // ------------------------------------------------------------------
   // Configuration registers
   // ------------------------------------------------------------------
   logic [BPP_W-1:0]     bpp_ff;
   logic [BPP_W-1:0]     bpp_in;
   logic [ROW_LEN_W-1:0] row_bytes_ff;
   logic [ROW_LEN_W-1:0] row_bytes_in;

   assign csr_ready = 1'b1;

   always_comb begin
      bpp_in       = bpp_ff;
      row_bytes_in = row_bytes_ff;
      if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_BPP:       bpp_in       = csr_data[BPP_W-1:0];
            CSR_ROW_BYTES: row_bytes_in = csr_data[ROW_LEN_W-1:0];
            default:       ;
         endcase
      end
   end

   // Out-of-range values are clamped to the legal range before use.
   logic [BPP_W-1:0] bpp_use;
   logic [COL_W-1:0] len_use;

   always_comb begin
      if (bpp_ff == '0) begin
         bpp_use = BPP_W'(1);
      end else if (32'(bpp_ff) > MAX_BPP) begin
         bpp_use = BPP_W'(MAX_BPP);
      end else begin
         bpp_use = bpp_ff;
      end
      if (row_bytes_ff == '0) begin
         len_use = COL_W'(1);
      end else if (32'(row_bytes_ff) > MAX_ROW_BYTES) begin
         len_use = COL_W'(MAX_ROW_BYTES);
      end else begin
         len_use = COL_W'(row_bytes_ff);
      end
   end

   // ------------------------------------------------------------------
   // Handshake. The working stage moves into the output register when the
   // output register is empty or being taken; a new word enters the working
   // stage whenever the working stage is empty or moving on.
   // ------------------------------------------------------------------
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic rsp_valid_in;
   logic out_advance;
   logic accept;

   assign out_advance = s1_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign req_stall   = s1_valid_ff && !out_advance;
   assign accept      = req_valid && !req_stall;

   assign s1_valid_in  = accept || (s1_valid_ff && !out_advance);
   assign rsp_valid_in = out_advance || (rsp_valid_ff && rsp_stall);

   // ------------------------------------------------------------------
   // Row position tracking, done as the word is accepted. This settles
   // whether the word is a filter byte, its column, its window slot, and
   // whether it closes the row.
   // ------------------------------------------------------------------
   logic [COL_W-1:0]  column_ff;
   logic [COL_W-1:0]  column_in;
   logic [SLOT_W-1:0] slot_ff;
   logic [SLOT_W-1:0] slot_in;
   filter_type        row_filter_ff;
   filter_type        row_filter_in;
   logic              first_row_ff;
   logic              first_row_in;

   logic [COL_W-1:0]      col_cur;
   logic [COL_W-1:0]      col_m1;
   logic [ROW_ADDR_W-1:0] s0_x;
   logic                  s0_is_filter;
   logic                  s0_eor;
   logic                  s0_first_row;
   logic                  s0_use_left;
   logic [3:0]            ls_wide;
   logic [SLOT_W-1:0]     s0_ls;

   assign col_cur      = req_first_of_image ? '0 : column_ff;
   assign col_m1       = col_cur - COL_W'(1);
   assign s0_x         = col_m1[ROW_ADDR_W-1:0];
   assign s0_is_filter = (col_cur == '0);
   assign s0_eor       = !s0_is_filter && (col_cur >= len_use);
   assign s0_first_row = req_first_of_image || first_row_ff;
   assign s0_use_left  = (32'(s0_x) >= 32'(bpp_use));

   // Window slot bytes_per_pixel back from the current one, wrapping round
   // the window.
   always_comb begin
      if (4'(slot_ff) >= 4'(bpp_use)) begin
         ls_wide = 4'(slot_ff) - 4'(bpp_use);
      end else begin
         ls_wide = 4'(slot_ff) + 4'(MAX_BPP) - 4'(bpp_use);
      end
   end
   assign s0_ls = ls_wide[SLOT_W-1:0];

   always_comb begin
      column_in     = column_ff;
      slot_in       = slot_ff;
      row_filter_in = row_filter_ff;
      first_row_in  = first_row_ff;
      if (accept) begin
         first_row_in = s0_first_row;
         if (s0_is_filter) begin
            // Unknown filter codes make the row pass through unchanged.
            row_filter_in = (req_data_byte <= 8'(FILT_PAETH)) ?
                            filter_type'(req_data_byte[2:0]) : FILT_PASS;
            column_in     = COL_W'(1);
            slot_in       = '0;
         end else begin
            if (s0_eor) begin
               column_in    = '0;
               first_row_in = 1'b0;
            end else begin
               column_in = col_cur + COL_W'(1);
            end
            if (32'(slot_ff) == MAX_BPP - 1) begin
               slot_in = '0;
            end else begin
               slot_in = slot_ff + SLOT_W'(1);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Line buffer holding the previous row. It is read as the word is
   // accepted, so the byte above is ready in the working stage. A row has
   // at least two words, so the write of a column always lands before the
   // next row reads that column.
   // ------------------------------------------------------------------
   logic [7:0] prior_row_mem [MAX_ROW_BYTES];
   logic [7:0] above_rd_ff;

   // ------------------------------------------------------------------
   // Working stage
   // ------------------------------------------------------------------
   logic [7:0]            s1_raw_ff;
   logic [7:0]            s1_raw_in;
   filter_type            s1_filter_ff;
   filter_type            s1_filter_in;
   logic                  s1_is_filter_ff;
   logic                  s1_is_filter_in;
   logic                  s1_eor_ff;
   logic                  s1_eor_in;
   logic [ROW_ADDR_W-1:0] s1_x_ff;
   logic [ROW_ADDR_W-1:0] s1_x_in;
   logic [SLOT_W-1:0]     s1_slot_ff;
   logic [SLOT_W-1:0]     s1_slot_in;
   logic [SLOT_W-1:0]     s1_ls_ff;
   logic [SLOT_W-1:0]     s1_ls_in;
   logic                  s1_use_left_ff;
   logic                  s1_use_left_in;
   logic                  s1_first_row_ff;
   logic                  s1_first_row_in;

   always_comb begin
      s1_raw_in       = s1_raw_ff;
      s1_filter_in    = s1_filter_ff;
      s1_is_filter_in = s1_is_filter_ff;
      s1_eor_in       = s1_eor_ff;
      s1_x_in         = s1_x_ff;
      s1_slot_in      = s1_slot_ff;
      s1_ls_in        = s1_ls_ff;
      s1_use_left_in  = s1_use_left_ff;
      s1_first_row_in = s1_first_row_ff;
      if (accept) begin
         s1_raw_in       = req_data_byte;
         s1_filter_in    = row_filter_ff;
         s1_is_filter_in = s0_is_filter;
         s1_eor_in       = s0_eor;
         s1_x_in         = s0_x;
         s1_slot_in      = slot_ff;
         s1_ls_in        = s0_ls;
         s1_use_left_in  = s0_use_left;
         s1_first_row_in = s0_first_row;
      end
   end

   // Recent reconstructed bytes and their above bytes, by window slot.
   logic [7:0] left_win_ff  [MAX_BPP];
   logic [7:0] left_win_in  [MAX_BPP];
   logic [7:0] above_win_ff [MAX_BPP];
   logic [7:0] above_win_in [MAX_BPP];

   logic [7:0] nb_a;
   logic [7:0] nb_b;
   logic [7:0] nb_c;
   logic [8:0] avg_sum;
   logic [7:0] recon;
   logic       mem_write;

   // Left neighbours before the row start count as zero, and so does the
   // whole row above on an image's first row.
   assign nb_b    = s1_first_row_ff ? 8'd0 : above_rd_ff;
   assign nb_a    = s1_use_left_ff ? left_win_ff[s1_ls_ff] : 8'd0;
   assign nb_c    = s1_use_left_ff ? above_win_ff[s1_ls_ff] : 8'd0;
   assign avg_sum = {1'b0, nb_a} + {1'b0, nb_b};

   always_comb begin
      case (s1_filter_ff)
         FILT_SUB:   recon = s1_raw_ff + nb_a;
         FILT_UP:    recon = s1_raw_ff + nb_b;
         FILT_AVG:   recon = s1_raw_ff + avg_sum[8:1];
         FILT_PAETH: recon = s1_raw_ff + paeth_pick(nb_a, nb_b, nb_c);
         default:    recon = s1_raw_ff;
      endcase
   end

   assign mem_write = out_advance && !s1_is_filter_ff;

   always_comb begin
      left_win_in  = left_win_ff;
      above_win_in = above_win_ff;
      if (mem_write) begin
         left_win_in[s1_slot_ff]  = recon;
         above_win_in[s1_slot_ff] = nb_b;
      end
   end

   // ------------------------------------------------------------------
   // Output register
   // ------------------------------------------------------------------
   logic [7:0] rsp_pixel_byte_ff;
   logic [7:0] rsp_pixel_byte_in;
   logic       rsp_is_filter_slot_ff;
   logic       rsp_is_filter_slot_in;
   logic       rsp_end_of_row_ff;
   logic       rsp_end_of_row_in;

   always_comb begin
      rsp_pixel_byte_in     = rsp_pixel_byte_ff;
      rsp_is_filter_slot_in = rsp_is_filter_slot_ff;
      rsp_end_of_row_in     = rsp_end_of_row_ff;
      if (out_advance) begin
         rsp_pixel_byte_in     = s1_is_filter_ff ? 8'd0 : recon;
         rsp_is_filter_slot_in = s1_is_filter_ff;
         rsp_end_of_row_in     = s1_eor_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_pixel_byte     = rsp_pixel_byte_ff;
   assign rsp_is_filter_slot = rsp_is_filter_slot_ff;
   assign rsp_end_of_row     = rsp_end_of_row_ff;

   // ------------------------------------------------------------------
   // Registers
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff        <= BPP_W'(4);
         row_bytes_ff  <= ROW_LEN_W'(1024);
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         column_ff     <= '0;
         slot_ff       <= '0;
         row_filter_ff <= FILT_NONE;
         first_row_ff  <= 1'b1;
         for (int i = 0; i < MAX_BPP; i++) begin
            left_win_ff[i]  <= 8'd0;
            above_win_ff[i] <= 8'd0;
         end
      end else begin
         bpp_ff        <= bpp_in;
         row_bytes_ff  <= row_bytes_in;
         s1_valid_ff   <= s1_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         column_ff     <= column_in;
         slot_ff       <= slot_in;
         row_filter_ff <= row_filter_in;
         first_row_ff  <= first_row_in;
         left_win_ff   <= left_win_in;
         above_win_ff  <= above_win_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_raw_ff             <= s1_raw_in;
      s1_filter_ff          <= s1_filter_in;
      s1_is_filter_ff       <= s1_is_filter_in;
      s1_eor_ff             <= s1_eor_in;
      s1_x_ff               <= s1_x_in;
      s1_slot_ff            <= s1_slot_in;
      s1_ls_ff              <= s1_ls_in;
      s1_use_left_ff        <= s1_use_left_in;
      s1_first_row_ff       <= s1_first_row_in;
      rsp_pixel_byte_ff     <= rsp_pixel_byte_in;
      rsp_is_filter_slot_ff <= rsp_is_filter_slot_in;
      rsp_end_of_row_ff     <= rsp_end_of_row_in;
   end

   always_ff @(posedge clock) begin
      if (mem_write) begin
         prior_row_mem[s1_x_ff] <= recon;
      end
      if (accept) begin
         above_rd_ff <= prior_row_mem[s0_x];
      end
   end

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
`include "png_row_unfilter_assert.svh"

   `PRU_ASSERT_SAME(a_stall_full, req_stall, s1_valid_ff && rsp_valid && rsp_stall, "early stall")
   `PRU_ASSERT_NEXT(a_filt_col, accept && s0_is_filter, column_ff == COL_W'(1), "filter column")
   `PRU_ASSERT_NEXT(a_row_end, accept && s0_eor, column_ff == '0 && !first_row_ff, "row end")
   `PRU_ASSERT_ALWAYS(a_col_max, column_ff <= COL_W'(MAX_ROW_BYTES), "column too big")

endmodule
